>>> design/gsig_pkg.sv
// Package for the grid strip index generator.
// Holds the sizing constants, code constants and shared structs; no dependencies.
package gsig_pkg;

   localparam int unsigned MAX_DIM = 4096;
   localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
   localparam int unsigned COUNT_W = $clog2(MAX_DIM);
   localparam int unsigned BASE_W = 2 * COUNT_W;
   localparam int unsigned INDEX_W = 32;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W = DIM_W;

   localparam logic [INDEX_W-1:0] RESTART_MARK = '1;

   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRIP_MODE = 2'd2;

   localparam logic [1:0] SEP_NONE = 2'd0;
   localparam logic [1:0] SEP_FIRST = 2'd1;
   localparam logic [1:0] SEP_SECOND = 2'd2;

   typedef enum logic [1:0] {
      MODE_LINE_RESTART = 2'd0,
      MODE_TRI_RESTART  = 2'd1,
      MODE_TRI_DEGEN    = 2'd2,
      MODE_UNSUPPORTED  = 2'd3
   } strip_mode_type;

   typedef struct packed {
      logic [DIM_W-1:0] grid_width;
      logic [DIM_W-1:0] grid_height;
      strip_mode_type   strip_mode;
   } cfg_type;

   typedef struct packed {
      logic [COUNT_W-1:0] col_count;
      logic [COUNT_W-1:0] row_count;
      logic               column_phase;
      logic               pair_half;
      logic [1:0]         separator_step;
      logic [BASE_W-1:0]  row_base;
   } seq_state_type;

   typedef struct packed {
      logic [INDEX_W-1:0] vertex_index;
      logic               is_restart;
      logic               is_last;
      logic               bad_setup;
   } rsp_type;

endpackage

>>> design/gsig_cfg.sv
// Configuration registers of the grid strip index generator.
// Depends on gsig_pkg; flags every in-range write so the sequence can rewind.
module gsig_cfg (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [gsig_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [gsig_pkg::CSR_DATA_W-1:0]    csr_write_data,
   output gsig_pkg::cfg_type                  cfg,
   output logic                               rewind
);
   import gsig_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    hit;

   always_comb begin
      cfg_in = cfg_ff;
      hit = 1'b0;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_GRID_WIDTH: begin
               cfg_in.grid_width = DIM_W'(csr_write_data);
               hit = 1'b1;
            end
            CSR_GRID_HEIGHT: begin
               cfg_in.grid_height = DIM_W'(csr_write_data);
               hit = 1'b1;
            end
            CSR_STRIP_MODE: begin
               cfg_in.strip_mode = strip_mode_type'(csr_write_data[1:0]);
               hit = 1'b1;
            end
            default: begin
               hit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width <= DIM_W'(2);
         cfg_ff.grid_height <= DIM_W'(2);
         cfg_ff.strip_mode <= MODE_LINE_RESTART;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
   assign rewind = hit;

endmodule

>>> design/gsig_step.sv
// Next-position and result logic for one request of the grid strip index generator.
// Depends on gsig_pkg; purely combinational.
module gsig_step (
   input  gsig_pkg::cfg_type       cfg,
   input  gsig_pkg::seq_state_type state_cur,
   input  logic                    begin_new,
   output gsig_pkg::seq_state_type state_nxt,
   output gsig_pkg::rsp_type       result
);
   import gsig_pkg::*;

   localparam seq_state_type ZERO_STATE = '0;

   seq_state_type    s;
   seq_state_type    n;
   rsp_type          r;
   logic [DIM_W-1:0] w;
   logic [DIM_W-1:0] wm1;
   logic [DIM_W-1:0] hm1;
   logic [DIM_W-1:0] hm2;
   logic [DIM_W-1:0] col_ext;
   logic [DIM_W-1:0] row_ext;
   logic             bad;
   logic             col_end;
   logic [BASE_W-1:0] base_w;
   logic [BASE_W-1:0] idx_cur;
   logic [BASE_W-1:0] idx_upper;
   logic [BASE_W-1:0] idx_deg1;
   logic [BASE_W:0]   idx_deg2;

   always_comb begin
      w = cfg.grid_width;
      wm1 = cfg.grid_width - DIM_W'(1);
      hm1 = cfg.grid_height - DIM_W'(1);
      hm2 = cfg.grid_height - DIM_W'(2);
      bad = (cfg.grid_width < DIM_W'(2)) || (cfg.grid_height < DIM_W'(2)) ||
            (cfg.grid_width > DIM_W'(MAX_DIM)) || (cfg.grid_height > DIM_W'(MAX_DIM));
      s = begin_new ? ZERO_STATE : state_cur;
      col_ext = DIM_W'(s.col_count);
      row_ext = DIM_W'(s.row_count);
      col_end = (col_ext == wm1);
      base_w = s.row_base + BASE_W'(w);
      idx_cur = s.row_base + BASE_W'(s.col_count);
      idx_upper = base_w + BASE_W'(s.col_count);
      idx_deg1 = base_w - BASE_W'(1);
      idx_deg2 = (BASE_W + 1)'(base_w) + (BASE_W + 1)'(w);

      n = s;
      r.vertex_index = INDEX_W'(idx_cur);
      r.is_restart = 1'b0;
      r.is_last = 1'b0;
      r.bad_setup = 1'b0;

      case (cfg.strip_mode)
         MODE_LINE_RESTART: begin
            if (s.separator_step != SEP_NONE) begin
               n.separator_step = SEP_NONE;
               if (!s.column_phase) begin
                  if (row_ext == hm1) begin
                     n.column_phase = 1'b1;
                     n.row_count = '0;
                     n.row_base = '0;
                     n.col_count = '0;
                  end else begin
                     n.row_count = s.row_count + COUNT_W'(1);
                     n.row_base = base_w;
                  end
               end else begin
                  n.col_count = s.col_count + COUNT_W'(1);
                  n.row_count = '0;
                  n.row_base = '0;
               end
               r.vertex_index = RESTART_MARK;
               r.is_restart = 1'b1;
            end else if (!s.column_phase) begin
               if (col_end) begin
                  n.col_count = '0;
                  n.separator_step = SEP_FIRST;
               end else begin
                  n.col_count = s.col_count + COUNT_W'(1);
               end
            end else if (row_ext == hm1) begin
               if (col_end) begin
                  n = ZERO_STATE;
                  r.is_last = 1'b1;
               end else begin
                  n.separator_step = SEP_FIRST;
               end
            end else begin
               n.row_count = s.row_count + COUNT_W'(1);
               n.row_base = base_w;
            end
         end
         MODE_TRI_RESTART, MODE_TRI_DEGEN: begin
            if (s.separator_step == SEP_FIRST) begin
               if (cfg.strip_mode == MODE_TRI_DEGEN) begin
                  n.separator_step = SEP_SECOND;
                  r.vertex_index = INDEX_W'(idx_deg1);
               end else begin
                  n.separator_step = SEP_NONE;
                  n.row_count = s.row_count + COUNT_W'(1);
                  n.row_base = base_w;
                  r.vertex_index = RESTART_MARK;
                  r.is_restart = 1'b1;
               end
            end else if (s.separator_step != SEP_NONE) begin
               n.separator_step = SEP_NONE;
               n.row_count = s.row_count + COUNT_W'(1);
               n.row_base = base_w;
               r.vertex_index = INDEX_W'(idx_deg2);
            end else if (!s.pair_half) begin
               n.pair_half = 1'b1;
               r.vertex_index = INDEX_W'(idx_upper);
            end else begin
               n.pair_half = 1'b0;
               if (col_end) begin
                  if (row_ext == hm2) begin
                     n = ZERO_STATE;
                     r.is_last = 1'b1;
                  end else begin
                     n.col_count = '0;
                     n.separator_step = SEP_FIRST;
                  end
               end else begin
                  n.col_count = s.col_count + COUNT_W'(1);
               end
            end
         end
         default: begin
            bad = 1'b1;
         end
      endcase

      if (bad) begin
         n = ZERO_STATE;
         r.vertex_index = '0;
         r.is_restart = 1'b0;
         r.is_last = 1'b0;
         r.bad_setup = 1'b1;
      end

      state_nxt = n;
      result = r;
   end

endmodule

>>> design/gsig_rsp_reg.sv
// Result register of the grid strip index generator.
// Depends on gsig_pkg; holds one response and frees itself as it is taken.
module gsig_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  gsig_pkg::rsp_type rsp_in,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output gsig_pkg::rsp_type rsp_out,
   output logic              space
);
   import gsig_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign space = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_out = data_ff;

endmodule

>>> design/grid_strip_index_generator.sv
// Grid strip index generator, top level.
// Uses gsig_pkg, gsig_cfg, gsig_step and gsig_rsp_reg.
// Each request returns one index of a grid mesh in line-strip or triangle-strip
// order; the response appears in the cycle after the request is accepted, and a new
// request is taken in every cycle while the response register is empty or being
// drained, so the block sustains one index per clock. The position in the sequence
// lives in a small set of counters that a request or any in-range register write
// updates. Registers must be written only while no response is outstanding.
module grid_strip_index_generator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_begin_new,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [gsig_pkg::INDEX_W-1:0]       rsp_vertex_index,
   output logic                               rsp_is_restart,
   output logic                               rsp_is_last,
   output logic                               rsp_bad_setup,
   input  logic                               csr_write_enable,
   input  logic [gsig_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [gsig_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import gsig_pkg::*;

   cfg_type       cfg;
   logic          rewind;
   seq_state_type seq_ff;
   seq_state_type seq_in;
   seq_state_type seq_step;
   rsp_type       step_rsp;
   rsp_type       rsp_out;
   logic          space;
   logic          accept;

   gsig_cfg u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg),
      .rewind           (rewind)
   );

   gsig_step u_step (
      .cfg       (cfg),
      .state_cur (seq_ff),
      .begin_new (req_begin_new),
      .state_nxt (seq_step),
      .result    (step_rsp)
   );

   gsig_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .rsp_in    (step_rsp),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_out   (rsp_out),
      .space     (space)
   );

   assign req_ready = space;
   assign accept = req_valid && space;

   always_comb begin
      seq_in = seq_ff;
      if (rewind) begin
         seq_in = '0;
      end else if (accept) begin
         seq_in = seq_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= '0;
      end else begin
         seq_ff <= seq_in;
      end
   end

   assign rsp_vertex_index = rsp_out.vertex_index;
   assign rsp_is_restart = rsp_out.is_restart;
   assign rsp_is_last = rsp_out.is_last;
   assign rsp_bad_setup = rsp_out.bad_setup;

endmodule

>>> design/gsig_checker.sv
// Port-level checks for the grid strip index generator.
// Uses gsig_pkg; bound to the top level at the end of this file.
module gsig_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [gsig_pkg::INDEX_W-1:0]       rsp_vertex_index,
   input logic                               rsp_is_restart,
   input logic                               rsp_is_last,
   input logic                               rsp_bad_setup
);
   import gsig_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_vertex_index) &&
      $stable(rsp_is_restart) && $stable(rsp_is_last) && $stable(rsp_bad_setup))
      else $error("Stalled response changed or was dropped.");

   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("Accepted request produced no response.");

   a_restart_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_restart |-> rsp_vertex_index == RESTART_MARK && !rsp_is_last &&
      !rsp_bad_setup)
      else $error("Restart response carries a wrong index or flags.");

   a_bad_setup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_setup |-> rsp_vertex_index == '0 && !rsp_is_restart &&
      !rsp_is_last)
      else $error("Error response carries a nonzero index or flags.");

endmodule

bind grid_strip_index_generator gsig_checker u_gsig_checker (.*);

>>> tb/grid_strip_index_generator_tb.sv
// Self-checking testbench for the grid strip index generator.
// Depends on gsig_pkg and grid_strip_index_generator; predicts every index in line and
// triangle strip order and compares each response with the oldest prediction.
module grid_strip_index_generator_tb;
   import gsig_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int RANDOM_REQUESTS = 1250;
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic req_begin_new;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [INDEX_W-1:0] rsp_vertex_index;
   logic rsp_is_restart;
   logic rsp_is_last;
   logic rsp_bad_setup;
   logic csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   int sender_idle_pct;
   int receiver_stall_pct;
   int mismatches = 0;
   int quiet_cycles = 0;

   logic [DIM_W-1:0] cfg_width;
   logic [DIM_W-1:0] cfg_height;
   strip_mode_type cfg_mode;
   logic [COUNT_W-1:0] col_pos;
   logic [COUNT_W-1:0] row_pos;
   logic in_columns;
   logic lower_half;
   logic [1:0] sep_step;
   logic [BASE_W-1:0] base_addr;

   rsp_type pending_indices[$];
   rsp_type oldest_index;

   grid_strip_index_generator dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_begin_new(req_begin_new),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_vertex_index(rsp_vertex_index),
      .rsp_is_restart(rsp_is_restart),
      .rsp_is_last(rsp_is_last),
      .rsp_bad_setup(rsp_bad_setup),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void rewind_grid();
      col_pos = '0;
      row_pos = '0;
      in_columns = 1'b0;
      lower_half = 1'b0;
      sep_step = SEP_NONE;
      base_addr = '0;
   endfunction

   function automatic void apply_register(logic [CSR_INDEX_W-1:0] index,
                                          logic [CSR_DATA_W-1:0] value);
      case (index)
         CSR_GRID_WIDTH: cfg_width = value;
         CSR_GRID_HEIGHT: cfg_height = value;
         CSR_STRIP_MODE: cfg_mode = strip_mode_type'(value[1:0]);
         default: return;
      endcase
      rewind_grid();
   endfunction

   function automatic rsp_type advance_grid(logic begin_new);
      rsp_type r;
      int unsigned w;
      int unsigned h;
      w = 32'(cfg_width);
      h = 32'(cfg_height);
      r = '0;
      if (w < 2 || h < 2 || w > MAX_DIM || h > MAX_DIM || cfg_mode == MODE_UNSUPPORTED) begin
         rewind_grid();
         r.bad_setup = 1'b1;
         return r;
      end
      if (begin_new)
         rewind_grid();
      if (cfg_mode == MODE_LINE_RESTART) begin
         if (sep_step != SEP_NONE) begin
            sep_step = SEP_NONE;
            if (!in_columns) begin
               if (row_pos == h - 1) begin
                  in_columns = 1'b1;
                  row_pos = '0;
                  base_addr = '0;
                  col_pos = '0;
               end else begin
                  row_pos = row_pos + COUNT_W'(1);
                  base_addr = base_addr + BASE_W'(w);
               end
            end else begin
               col_pos = col_pos + COUNT_W'(1);
               row_pos = '0;
               base_addr = '0;
            end
            r.vertex_index = RESTART_MARK;
            r.is_restart = 1'b1;
         end else begin
            r.vertex_index = INDEX_W'(base_addr) + INDEX_W'(col_pos);
            if (!in_columns) begin
               if (col_pos == w - 1) begin
                  col_pos = '0;
                  sep_step = SEP_FIRST;
               end else begin
                  col_pos = col_pos + COUNT_W'(1);
               end
            end else if (row_pos == h - 1) begin
               if (col_pos == w - 1) begin
                  rewind_grid();
                  r.is_last = 1'b1;
               end else begin
                  sep_step = SEP_FIRST;
               end
            end else begin
               row_pos = row_pos + COUNT_W'(1);
               base_addr = base_addr + BASE_W'(w);
            end
         end
      end else if (sep_step == SEP_FIRST) begin
         if (cfg_mode == MODE_TRI_DEGEN) begin
            sep_step = SEP_SECOND;
            r.vertex_index = INDEX_W'(base_addr) + w - 1;
         end else begin
            sep_step = SEP_NONE;
            row_pos = row_pos + COUNT_W'(1);
            base_addr = base_addr + BASE_W'(w);
            r.vertex_index = RESTART_MARK;
            r.is_restart = 1'b1;
         end
      end else if (sep_step != SEP_NONE) begin
         r.vertex_index = INDEX_W'(base_addr) + w + w;
         sep_step = SEP_NONE;
         row_pos = row_pos + COUNT_W'(1);
         base_addr = base_addr + BASE_W'(w);
      end else if (!lower_half) begin
         lower_half = 1'b1;
         r.vertex_index = INDEX_W'(base_addr) + w + INDEX_W'(col_pos);
      end else begin
         r.vertex_index = INDEX_W'(base_addr) + INDEX_W'(col_pos);
         lower_half = 1'b0;
         if (col_pos == w - 1) begin
            if (row_pos == h - 2) begin
               rewind_grid();
               r.is_last = 1'b1;
            end else begin
               col_pos = '0;
               sep_step = SEP_FIRST;
            end
         end else begin
            col_pos = col_pos + COUNT_W'(1);
         end
      end
      return r;
   endfunction

   task automatic send_request(input logic begin_new);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_begin_new <= begin_new;
      @(negedge clock);
      while (!req_ready)
         @(negedge clock);
      @(posedge clock);
      pending_indices.push_back(advance_grid(begin_new));
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      req_valid <= 1'b0;
      while (pending_indices.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      apply_register(index, value);
      @(posedge clock);
   endtask

   task automatic configure_grid(input logic [DIM_W-1:0] width, input logic [DIM_W-1:0] height,
                                 input strip_mode_type mode);
      write_register(CSR_GRID_WIDTH, width);
      write_register(CSR_GRID_HEIGHT, height);
      write_register(CSR_STRIP_MODE, CSR_DATA_W'(mode));
   endtask

   task automatic set_idle(input int sender_pct, input int receiver_pct);
      sender_idle_pct = sender_pct;
      receiver_stall_pct = receiver_pct;
   endtask

   // The reset grid is 2 by 2 in line strips: eleven indices, then the sequence wraps.
   task automatic test_default_grid();
      repeat (12) send_request(1'b0);
   endtask

   task automatic test_bad_setup();
      write_register(CSR_GRID_WIDTH, 13'd0);
      send_request(1'b0);
      write_register(CSR_GRID_WIDTH, 13'd1);
      send_request(1'b1);
      configure_grid(13'd2, 13'd0, MODE_TRI_RESTART);
      send_request(1'b0);
      configure_grid(13'd2, 13'd2, MODE_UNSUPPORTED);
      send_request(1'b0);
   endtask

   task automatic test_large_grid();
      configure_grid(13'd4096, 13'd4096, MODE_TRI_DEGEN);
      repeat (3) send_request(1'b0);
      send_request(1'b1);
      configure_grid(13'd4095, 13'd4096, MODE_LINE_RESTART);
      repeat (2) send_request(1'b0);
   endtask

   // A write to an index with no register behind it must not rewind the sequence.
   task automatic test_unused_register();
      configure_grid(13'd3, 13'd2, MODE_TRI_RESTART);
      repeat (2) send_request(1'b0);
      write_register(CSR_UNUSED, 13'h1fff);
      repeat (2) send_request(1'b0);
   endtask

   task automatic test_random_grids();
      int sent;
      int kind;
      int count;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      strip_mode_type mode;
      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         if (sent < RANDOM_REQUESTS / 3)
            set_idle(15, 48);
         else if (sent < 2 * RANDOM_REQUESTS / 3)
            set_idle(48, 15);
         else
            set_idle(0, 0);
         kind = $urandom_range(99);
         mode = strip_mode_type'($urandom_range(2));
         if (kind < 8) begin
            width = DIM_W'($urandom_range(2, 6));
            height = DIM_W'($urandom_range(2, 6));
            case ($urandom_range(2))
               0: width = DIM_W'($urandom_range(1));
               1: height = DIM_W'($urandom_range(1));
               default: mode = MODE_UNSUPPORTED;
            endcase
            count = $urandom_range(1, 4);
         end else if (kind < 14) begin
            width = DIM_W'($urandom_range(2, MAX_DIM));
            height = DIM_W'($urandom_range(2, MAX_DIM));
            count = $urandom_range(5, 30);
         end else begin
            width = DIM_W'($urandom_range(2, 5));
            height = DIM_W'($urandom_range(2, 5));
            count = $urandom_range(10, 120);
         end
         if ($urandom_range(5) == 0)
            write_register(CSR_UNUSED, CSR_DATA_W'($urandom_range(8191)));
         configure_grid(width, height, mode);
         repeat (count) begin
            send_request($urandom_range(99) < 4);
            sent++;
         end
      end
   endtask

   task automatic report_field(input string name, input logic [INDEX_W-1:0] want,
                               input logic [INDEX_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);

   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_indices.size() == 0) begin
            $display("%0t: response with no request outstanding, expected none, got %h",
                     $time, rsp_vertex_index);
            mismatches++;
         end else begin
            oldest_index = pending_indices.pop_front();
            report_field("vertex_index", oldest_index.vertex_index, rsp_vertex_index);
            report_field("is_restart", INDEX_W'(oldest_index.is_restart),
                         INDEX_W'(rsp_is_restart));
            report_field("is_last", INDEX_W'(oldest_index.is_last), INDEX_W'(rsp_is_last));
            report_field("bad_setup", INDEX_W'(oldest_index.bad_setup),
                         INDEX_W'(rsp_bad_setup));
         end
      end
   end

   always @(negedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: timeout, no request or response moved for %0d cycles",
                  $time, WATCHDOG_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_begin_new <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index <= '0;
      csr_write_data <= '0;
      cfg_width = 13'd2;
      cfg_height = 13'd2;
      cfg_mode = MODE_LINE_RESTART;
      rewind_grid();
      set_idle(15, 48);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_grid();
      test_bad_setup();
      test_large_grid();
      test_unused_register();
      test_random_grids();
      req_valid <= 1'b0;
      while (pending_indices.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
